FILE: rtl/ist_pkg.sv
package ist_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int TMP_W = $clog2(MAX_RANGES + 3);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_GET   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_start;
        logic [31:0] found_end;
        logic        last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture operand, reset scan
        logic rd_issue;  // read live entry at scan index
        logic proc;      // process registered read data
        logic finish;    // end of scan, flush pending operand
        logic cp_issue;  // read scratch entry at copy index
        logic cp_write;  // write registered scratch data to live table
        logic commit;    // set count from scratch count
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;   // scan index reached count
        logic copy_done;   // copy index reached scratch count
        logic invalid;
        logic overflow;    // scratch count above capacity
        logic get_hit;     // current processed entry matches get
        logic any_hit;
        logic [1:0] op;
    } stat_t;

endpackage

FILE: rtl/ist_if.sv
interface ist_in_if;
    import ist_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    modport source (output valid, operation, range_start, range_end, input ready);
    modport sink (input valid, operation, range_start, range_end, output ready);
endinterface

interface ist_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] found_start;
    logic signed [31:0] found_end;
    logic        last;
    modport source (output valid, status, found_start, found_end, last, input ready);
    modport sink (input valid, status, found_start, found_end, last, output ready);
endinterface

FILE: rtl/ist_ram.sv
module ist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/ist_datapath.sv
module ist_datapath
    import ist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  operation,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    output logic [31:0] hit_start,
    output logic [31:0] hit_end
);
    localparam int TDEPTH = MAX_RANGES + 2;

    logic [1:0]        op_reg;
    logic signed [31:0] s_reg, e_reg;
    logic              placed_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [TMP_W-1:0]  n_reg;
    logic [TMP_W-1:0]  cp_reg;
    logic              any_reg;

    logic [63:0]       live_rd, tmp_rd;
    logic              live_we;
    logic signed [31:0] rs, re;
    logic [CNT_W-1:0]  prev_idx;
    logic [IDX_W-1:0]  live_raddr;

    // up to two scratch pushes per processed entry: a then b
    logic              push_a, push_b;
    logic [63:0]       a_data, b_data;
    logic              tmp_we;
    logic [TMP_W-1:0]  tmp_waddr;
    logic [63:0]       tmp_wdata;
    logic              hold_b_reg;
    logic [63:0]       b_data_reg;
    logic signed [31:0] s_next, e_next;
    logic              placed_next;
    logic              hit;

    assign rs = live_rd[63:32];
    assign re = live_rd[31:0];
    assign hit = (rs < e_reg) && (s_reg < re);

    // keep reading the entry in process so a stalled get keeps its data
    assign prev_idx = idx_reg - 1'b1;
    assign live_raddr = cmd.rd_issue ? idx_reg[IDX_W-1:0] : prev_idx[IDX_W-1:0];

    always_comb
    begin
        push_a = 1'b0;
        push_b = 1'b0;
        a_data = live_rd;
        b_data = live_rd;
        s_next = s_reg;
        e_next = e_reg;
        placed_next = placed_reg;
        if (cmd.proc)
        begin
            unique case (op_reg)
                OP_ADD:
                begin
                    if (placed_reg)
                    begin
                        push_a = 1'b1;
                    end
                    else if (rs <= e_reg && s_reg <= re)
                    begin
                        if (rs < s_reg) s_next = rs;
                        if (re > e_reg) e_next = re;
                    end
                    else if (rs < s_reg)
                    begin
                        push_a = 1'b1;
                    end
                    else
                    begin
                        push_a = 1'b1;
                        a_data = {s_reg, e_reg};
                        push_b = 1'b1;
                        placed_next = 1'b1;
                    end
                end
                OP_DEL:
                begin
                    if (hit)
                    begin
                        if (rs < s_reg)
                        begin
                            push_a = 1'b1;
                            a_data = {rs, s_reg};
                            if (e_reg < re)
                            begin
                                push_b = 1'b1;
                                b_data = {e_reg, re};
                            end
                        end
                        else if (e_reg < re)
                        begin
                            push_a = 1'b1;
                            a_data = {e_reg, re};
                        end
                    end
                    else
                    begin
                        push_a = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.finish && op_reg == OP_ADD && !placed_reg)
        begin
            push_a = 1'b1;
            a_data = {s_reg, e_reg};
        end
    end

    // a second push is written in the following cycle from a holding register
    always_comb
    begin
        tmp_we = 1'b0;
        tmp_wdata = a_data;
        tmp_waddr = n_reg;
        if (hold_b_reg)
        begin
            tmp_we = n_reg < TMP_W'(TDEPTH);
            tmp_wdata = b_data_reg;
        end
        else if (push_a)
        begin
            tmp_we = n_reg < TMP_W'(TDEPTH);
        end
    end

    always_ff @(posedge clk)
    begin
        b_data_reg <= b_data;
        if (cmd.load)
        begin
            op_reg <= operation;
            s_reg <= range_start;
            e_reg <= range_end;
        end
        else
        begin
            s_reg <= s_next;
            e_reg <= e_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            n_reg <= '0;
            cp_reg <= '0;
            placed_reg <= 1'b0;
            hold_b_reg <= 1'b0;
            any_reg <= 1'b0;
        end
        else
        begin
            hold_b_reg <= push_b;
            if (cmd.load)
            begin
                idx_reg <= '0;
                n_reg <= '0;
                cp_reg <= '0;
                placed_reg <= 1'b0;
                any_reg <= 1'b0;
            end
            else
            begin
                placed_reg <= placed_next;
                if (cmd.rd_issue) idx_reg <= idx_reg + 1'b1;
                if (cmd.cp_issue) cp_reg <= cp_reg + 1'b1;
                if (hold_b_reg || push_a) n_reg <= n_reg + 1'b1;
                if (cmd.proc && hit && op_reg == OP_GET) any_reg <= 1'b1;
            end
            if (cmd.clear) count_reg <= '0;
            else if (cmd.commit) count_reg <= CNT_W'(n_reg);
        end
    end

    logic [TMP_W-1:0] wr_idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) wr_idx_reg <= '0;
        else if (cmd.load) wr_idx_reg <= '0;
        else if (cmd.cp_write) wr_idx_reg <= wr_idx_reg + 1'b1;
    end
    assign live_we = cmd.cp_write;

    ist_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_live (
        .clk   (clk),
        .we    (live_we),
        .waddr (wr_idx_reg[IDX_W-1:0]),
        .wdata (tmp_rd),
        .raddr (live_raddr),
        .rdata (live_rd)
    );

    ist_ram #(.WIDTH(64), .DEPTH(TDEPTH)) u_tmp (
        .clk   (clk),
        .we    (tmp_we),
        .waddr (tmp_waddr[$clog2(TDEPTH)-1:0]),
        .wdata (tmp_wdata),
        .raddr (cp_reg[$clog2(TDEPTH)-1:0]),
        .rdata (tmp_rd)
    );

    assign hit_start = live_rd[63:32];
    assign hit_end = live_rd[31:0];

    assign stat.scan_done = idx_reg >= count_reg;
    assign stat.copy_done = cp_reg >= n_reg;
    assign stat.invalid = !(s_reg < e_reg);
    assign stat.overflow = n_reg > TMP_W'(MAX_RANGES);
    assign stat.get_hit = hit;
    assign stat.any_hit = any_reg;
    assign stat.op = op_reg;
endmodule

FILE: rtl/ist_ctrl.sv
module ist_ctrl
    import ist_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output cmd_t  cmd,
    input  stat_t stat,
    input  logic [31:0] hit_start,
    input  logic [31:0] hit_end,
    output logic  out_valid,
    input  logic  out_ready,
    output result_t out_data
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_PROC  = 8'b0000_1000,
        S_FIN   = 8'b0001_0000,
        S_COPYR = 8'b0010_0000,
        S_COPYW = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    logic    ov_reg, ov_next;
    result_t res_reg, res_next;
    logic    bsy_reg, bsy_next;   // get match pending in output
    logic    settle_reg, settle_next; // wait while a second push may still be written

    // output holding register frees before next get match is presented
    logic out_free;
    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        res_next = res_reg;
        bsy_next = bsy_reg;
        settle_next = 1'b0;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.op == OP_CLEAR)
                begin
                    cmd.clear = 1'b1;
                    res_next = '{ST_OK, 32'd0, 32'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else if (stat.invalid)
                begin
                    res_next = '{ST_INVALID, 32'd0, 32'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (stat.op == OP_GET && stat.get_hit && !out_free)
                begin
                    state_next = S_PROC;
                end
                else
                begin
                    cmd.proc = 1'b1;
                    settle_next = 1'b1;
                    if (stat.op == OP_GET && stat.get_hit)
                    begin
                        // hold match; last decided later
                        if (bsy_reg)
                        begin
                            ov_next = 1'b1;
                        end
                        res_next = '{ST_OK, hit_start, hit_end, 1'b0};
                        bsy_next = 1'b1;
                    end
                    state_next = S_READ;
                end
            end
            S_FIN:
            begin
                if (settle_reg)
                begin
                    state_next = S_FIN;
                end
                else if (stat.op == OP_GET)
                begin
                    if (!out_free)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        if (bsy_reg) res_next.last = 1'b1;
                        else res_next = '{ST_NONE, 32'd0, 32'd0, 1'b1};
                        bsy_next = 1'b0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_COPYR;
                end
            end
            S_COPYR:
            begin
                if (settle_reg)
                begin
                    state_next = S_COPYR;
                end
                else if (stat.overflow)
                begin
                    res_next = '{ST_FULL, 32'd0, 32'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else if (stat.copy_done)
                begin
                    cmd.commit = 1'b1;
                    res_next = '{ST_OK, 32'd0, 32'd0, 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.cp_issue = 1'b1;
                    state_next = S_COPYW;
                end
            end
            S_COPYW:
            begin
                cmd.cp_write = 1'b1;
                state_next = S_COPYR;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_FIN && !settle_reg && stat.op != OP_GET)
        begin
            settle_next = 1'b1;
        end
    end

    // get match: previous held match is released when the next arrives
    result_t pend_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROC && cmd.proc && stat.op == OP_GET && stat.get_hit
            && bsy_reg)
        begin
            pend_reg <= res_reg;
        end
        else if (state_reg == S_EMIT && out_free)
        begin
            pend_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            bsy_reg <= 1'b0;
            settle_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            bsy_reg <= bsy_next;
            settle_reg <= settle_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data = pend_reg;
endmodule

FILE: rtl/interval_set_table_top.sv
// interval_set_table_top keeps up to MAX_RANGES sorted, disjoint half-open
// ranges and takes one operation per input transaction: add (merging every
// overlapping or touching range), delete (which can split a range), get
// (one result transaction per overlapping range, in ascending order, last
// flag on the final one, or one no-match result) and clear. An add, delete
// or get with start not below end is ignored with an invalid status; an
// add or delete that would exceed capacity leaves the table unchanged and
// reports full. Operations run one at a time. An add or delete scans the
// live table entry by entry into a scratch table, then copies the scratch
// table back entry by entry; a get scans only. The scan pace is set by the
// registered read port of the table memory. A finished result sits in an
// output register while the next transaction is accepted.
module interval_set_table_top
    import ist_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ist_in_if.sink    in_ch,
    ist_out_if.source out_ch
);
    cmd_t    cmd;
    stat_t   stat;
    result_t res;
    logic [31:0] hit_start, hit_end;

    // sequencer: scan, rebuild, copy back and result ordering
    ist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .stat      (stat),
        .hit_start (hit_start),
        .hit_end   (hit_end),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (res)
    );

    // operand registers, live and scratch tables, merge and split logic
    ist_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (in_ch.operation),
        .range_start (in_ch.range_start),
        .range_end   (in_ch.range_end),
        .hit_start   (hit_start),
        .hit_end     (hit_end)
    );

    assign out_ch.status      = res.status;
    assign out_ch.found_start = res.found_start;
    assign out_ch.found_end   = res.found_end;
    assign out_ch.last        = res.last;
endmodule
